>>> rtl/ltsc_pkg.sv
// Package: status codes, character constants and shared types of the term checker.
package ltsc_pkg;

  localparam logic [3:0] ST_OK           = 4'd0;
  localparam logic [3:0] ST_ILLEGAL_START = 4'd1;
  localparam logic [3:0] ST_EMPTY        = 4'd2;
  localparam logic [3:0] ST_EXTRA_CLOSE  = 4'd3;
  localparam logic [3:0] ST_FACTS_ADJ    = 4'd4;
  localparam logic [3:0] ST_OPS_ADJ      = 4'd5;
  localparam logic [3:0] ST_UNKNOWN      = 4'd6;
  localparam logic [3:0] ST_TRAILING_OP  = 4'd7;
  localparam logic [3:0] ST_OPEN_BRACE   = 4'd8;
  localparam logic [3:0] ST_BOTH         = 4'd9;
  localparam logic [3:0] ST_TOO_DEEP     = 4'd10;

  localparam logic [7:0] CH_AND   = 8'h2B;  // '+'
  localparam logic [7:0] CH_XOR   = 8'h5E;  // '^'
  localparam logic [7:0] CH_OR    = 8'h7C;  // '|'
  localparam logic [7:0] CH_OPEN  = 8'h28;  // '('
  localparam logic [7:0] CH_CLOSE = 8'h29;  // ')'
  localparam logic [7:0] CH_NOT   = 8'h21;  // '!'
  localparam logic [7:0] CH_A     = 8'h41;
  localparam logic [7:0] CH_Z     = 8'h5A;

  typedef struct packed {
    logic fact_seen;
    logic operator_pending;
  } flags_t;

  typedef struct packed {
    logic        term_ok;
    logic [3:0]  status;
    logic [15:0] error_index;
    logic [7:0]  error_char;
  } verdict_t;

endpackage

>>> rtl/ltsc_if.sv
// Interfaces: character input channel and verdict output channel.
interface ltsc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;
  logic       term_end;

  modport source (output valid, output char_code, output term_end, input ready);
  modport sink (input valid, input char_code, input term_end, output ready);
endinterface

interface ltsc_out_if;
  logic        valid;
  logic        ready;
  logic        term_ok;
  logic [3:0]  status;
  logic [15:0] error_index;
  logic [7:0]  error_char;

  modport source (output valid, output term_ok, output status, output error_index,
                  output error_char, input ready);
  modport sink (input valid, input term_ok, input status, input error_index,
                input error_char, output ready);
endinterface

>>> rtl/logic_term_syntax_checker.sv
// Top level: boolean term syntax checker with input and verdict registers.
//
// term_in carries one character per transfer (char_code) or, with term_end
// set, the terminator of a term. Each terminator yields exactly one transfer
// on verdict: term_ok, status, error_index and error_char. Other characters
// yield nothing on verdict; the first error in a term is latched and the
// characters after it are only counted.
//
// A character is registered in the input register at its transfer and is
// processed from there; a terminator then loads its verdict into the output
// register. One character is taken per cycle, except while a terminator
// waits in the input register for a stalled verdict.
//
// When verdict is stalled, characters keep flowing; only a terminator waits
// in the input register until the output register is free, and ready stays
// low on term_in while it waits. After the verdict the checker is ready for
// a new term.
//
// rst (synchronous, active high) empties both registers and clears the
// depth, flags, position and latched error.
module logic_term_syntax_checker #(
  parameter int MAX_DEPTH     = 255,
  parameter int POSITION_BITS = 16
) (
  input logic        clk,
  input logic        rst,
  ltsc_in_if.sink    term_in,
  ltsc_out_if.source verdict
);
  import ltsc_pkg::*;

  localparam int DEPTH_BITS = $clog2(MAX_DEPTH + 1);

  logic                     in_valid;
  logic [7:0]               in_char;
  logic                     in_end;
  logic [DEPTH_BITS-1:0]    depth;
  logic [DEPTH_BITS-1:0]    depth_next;
  flags_t                   flags;
  flags_t                   flags_next;
  logic [POSITION_BITS-1:0] position;
  logic [POSITION_BITS-1:0] position_next;
  logic [3:0]               lat_status;
  logic [3:0]               lat_status_next;
  logic [POSITION_BITS-1:0] lat_index;
  logic [POSITION_BITS-1:0] lat_index_next;
  logic [7:0]               lat_char;
  logic [7:0]               lat_char_next;
  verdict_t                 result;
  verdict_t                 out_data;
  logic                     out_valid;
  logic                     out_free;
  logic                     proc_fire;

  assign out_free      = !out_valid || verdict.ready;
  assign proc_fire     = in_valid && (!in_end || out_free);
  assign term_in.ready = !in_valid || proc_fire;

  ltsc_step #(
    .MAX_DEPTH    (MAX_DEPTH),
    .POSITION_BITS(POSITION_BITS),
    .DEPTH_BITS   (DEPTH_BITS)
  ) u_step (
    .char_code      (in_char),
    .term_end       (in_end),
    .depth          (depth),
    .flags          (flags),
    .position       (position),
    .lat_status     (lat_status),
    .lat_index      (lat_index),
    .lat_char       (lat_char),
    .depth_next     (depth_next),
    .flags_next     (flags_next),
    .position_next  (position_next),
    .lat_status_next(lat_status_next),
    .lat_index_next (lat_index_next),
    .lat_char_next  (lat_char_next),
    .verdict        (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (term_in.ready) begin
      in_valid <= term_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (term_in.valid && term_in.ready) begin
      in_char <= term_in.char_code;
      in_end  <= term_in.term_end;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      depth      <= '0;
      flags      <= '0;
      position   <= '0;
      lat_status <= ST_OK;
      lat_index  <= '0;
      lat_char   <= '0;
    end else if (proc_fire) begin
      depth      <= depth_next;
      flags      <= flags_next;
      position   <= position_next;
      lat_status <= lat_status_next;
      lat_index  <= lat_index_next;
      lat_char   <= lat_char_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (proc_fire && in_end) begin
      out_valid <= 1'b1;
    end else if (verdict.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (proc_fire && in_end) begin
      out_data <= result;
    end
  end

  assign verdict.valid       = out_valid;
  assign verdict.term_ok     = out_data.term_ok;
  assign verdict.status      = out_data.status;
  assign verdict.error_index = out_data.error_index;
  assign verdict.error_char  = out_data.error_char;

  a_end_clears: assert property (@(posedge clk) disable iff (rst)
    (proc_fire && in_end) |=> (position == '0 && depth == '0 && lat_status == ST_OK))
    else $error("state not cleared after terminator");

  a_end_loads: assert property (@(posedge clk) disable iff (rst)
    (proc_fire && in_end) |=> out_valid)
    else $error("verdict not loaded after terminator");

  a_error_sticky: assert property (@(posedge clk) disable iff (rst)
    (lat_status != ST_OK && !(proc_fire && in_end)) |=>
      (lat_status == $past(lat_status) && lat_index == $past(lat_index)))
    else $error("latched error changed inside a term");

  a_ok_clean: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.term_ok) |->
      (out_data.status == ST_OK && out_data.error_index == 16'd0))
    else $error("ok verdict with error fields set");

endmodule

>>> rtl/ltsc_step.sv
// Step logic: classifies one character and computes next state and verdict.
module ltsc_step #(
  parameter int MAX_DEPTH     = 255,
  parameter int POSITION_BITS = 16,
  parameter int DEPTH_BITS    = $clog2(MAX_DEPTH + 1)
) (
  input  logic [7:0]               char_code,
  input  logic                     term_end,
  input  logic [DEPTH_BITS-1:0]    depth,
  input  ltsc_pkg::flags_t         flags,
  input  logic [POSITION_BITS-1:0] position,
  input  logic [3:0]               lat_status,
  input  logic [POSITION_BITS-1:0] lat_index,
  input  logic [7:0]               lat_char,
  output logic [DEPTH_BITS-1:0]    depth_next,
  output ltsc_pkg::flags_t         flags_next,
  output logic [POSITION_BITS-1:0] position_next,
  output logic [3:0]               lat_status_next,
  output logic [POSITION_BITS-1:0] lat_index_next,
  output logic [7:0]               lat_char_next,
  output ltsc_pkg::verdict_t       verdict
);
  import ltsc_pkg::*;

  localparam logic [DEPTH_BITS-1:0] DEPTH_LIMIT = DEPTH_BITS'(MAX_DEPTH);

  logic                     is_op;
  logic                     is_fact;
  logic [3:0]               st;
  logic [POSITION_BITS-1:0] idx;
  logic [7:0]               ech;
  logic [POSITION_BITS+15:0] idx_wide;

  assign is_op   = (char_code == CH_AND) || (char_code == CH_XOR) || (char_code == CH_OR);
  assign is_fact = (char_code >= CH_A) && (char_code <= CH_Z);

  // verdict at the terminator
  always_comb begin
    st  = ST_OK;
    idx = '0;
    ech = '0;
    if (lat_status != ST_OK) begin
      st  = lat_status;
      idx = lat_index;
      ech = lat_char;
    end else if (position == '0) begin
      st = ST_EMPTY;
    end else if (flags.operator_pending || depth != '0) begin
      if (flags.operator_pending && depth != '0) begin
        st = ST_BOTH;
      end else if (flags.operator_pending) begin
        st = ST_TRAILING_OP;
      end else begin
        st = ST_OPEN_BRACE;
      end
      idx = position;
    end
    if (st == ST_ILLEGAL_START) begin
      idx = '0;
    end
  end

  assign idx_wide            = {16'b0, idx};
  assign verdict.term_ok     = (st == ST_OK);
  assign verdict.status      = st;
  assign verdict.error_index = idx_wide[15:0];
  assign verdict.error_char  = ech;

  always_comb begin
    depth_next      = depth;
    flags_next      = flags;
    position_next   = position;
    lat_status_next = lat_status;
    lat_index_next  = lat_index;
    lat_char_next   = lat_char;
    if (term_end) begin
      depth_next      = '0;
      flags_next      = '0;
      position_next   = '0;
      lat_status_next = ST_OK;
      lat_index_next  = '0;
      lat_char_next   = '0;
    end else begin
      if (lat_status == ST_OK) begin
        if (position == '0 && is_op) begin
          lat_status_next = ST_ILLEGAL_START;
          lat_index_next  = position;
          lat_char_next   = '0;
        end else if (char_code == CH_OPEN) begin
          if (depth >= DEPTH_LIMIT) begin
            lat_status_next = ST_TOO_DEEP;
            lat_index_next  = position;
            lat_char_next   = '0;
          end else begin
            depth_next = depth + 1'b1;
          end
        end else if (char_code == CH_CLOSE) begin
          if (depth == '0) begin
            lat_status_next = ST_EXTRA_CLOSE;
            lat_index_next  = position;
            lat_char_next   = '0;
          end else begin
            depth_next = depth - 1'b1;
          end
        end else if (is_fact) begin
          if (!flags.fact_seen) begin
            flags_next.fact_seen        = 1'b1;
            flags_next.operator_pending = 1'b0;
          end else begin
            lat_status_next = ST_FACTS_ADJ;
            lat_index_next  = position;
            lat_char_next   = '0;
          end
        end else if (is_op) begin
          if (flags.fact_seen && !flags.operator_pending) begin
            flags_next.fact_seen        = 1'b0;
            flags_next.operator_pending = 1'b1;
          end else begin
            lat_status_next = ST_OPS_ADJ;
            lat_index_next  = position;
            lat_char_next   = '0;
          end
        end else if (char_code != CH_NOT) begin
          lat_status_next = ST_UNKNOWN;
          lat_index_next  = position;
          lat_char_next   = char_code;
        end
      end
      if (position != '1) begin
        position_next = position + 1'b1;
      end
    end
  end

endmodule

>>> tb/testbench.sv
// Testbench for logic_term_syntax_checker: directed probe table plus random terms, self-checked.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import ltsc_pkg::*;

  localparam int MAX_DEPTH    = 255;
  localparam int POS_MAX      = 65535;
  localparam int RANDOM_ITEMS = 1200;
  localparam int IDLE_LIMIT   = 2000;

  typedef struct {
    logic [7:0]  c;
    logic        last;
    bit          typed;
    logic [3:0]  status;
    logic [15:0] index;
    logic [7:0]  bad;
  } probe_t;

  logic clk;
  logic rst;

  ltsc_in_if  term_in ();
  ltsc_out_if verdict ();

  logic_term_syntax_checker dut (
    .clk     (clk),
    .rst     (rst),
    .term_in (term_in),
    .verdict (verdict)
  );

  // predictor state
  int          depth = 0;
  bit          fact_seen = 0;
  bit          op_pending = 0;
  int          char_pos = 0;
  logic [3:0]  err_status = ST_OK;
  logic [15:0] err_index = '0;
  logic [7:0]  err_char = '0;

  verdict_t    pending_verdicts[$];
  logic [7:0]  term_q[$];
  int unsigned items_sent = 0;
  int unsigned mismatches = 0;
  int unsigned idle_cycles = 0;
  bit          steady = 0;

  probe_t probes [27] = '{
    '{8'h00,    1'b1, 1'b1, ST_EMPTY,         16'd0, 8'h00},
    '{CH_AND,   1'b0, 1'b0, ST_OK,            16'd0, 8'h00},
    '{8'h00,    1'b1, 1'b1, ST_ILLEGAL_START, 16'd0, 8'h00},
    '{8'hFF,    1'b0, 1'b0, ST_OK,            16'd0, 8'h00},
    '{8'hFF,    1'b1, 1'b1, ST_UNKNOWN,       16'd0, 8'hFF},
    '{8'h00,    1'b0, 1'b0, ST_OK,            16'd0, 8'h00},
    '{8'h00,    1'b1, 1'b1, ST_UNKNOWN,       16'd0, 8'h00},
    '{CH_A,     1'b0, 1'b0, ST_OK,            16'd0, 8'h00},
    '{CH_NOT,   1'b0, 1'b0, ST_OK,            16'd0, 8'h00},
    '{"B",      1'b0, 1'b0, ST_OK,            16'd0, 8'h00},
    '{8'h00,    1'b1, 1'b1, ST_FACTS_ADJ,     16'd2, 8'h00},
    '{CH_Z,     1'b0, 1'b0, ST_OK,            16'd0, 8'h00},
    '{CH_OR,    1'b0, 1'b0, ST_OK,            16'd0, 8'h00},
    '{CH_XOR,   1'b0, 1'b0, ST_OK,            16'd0, 8'h00},
    '{CH_AND,   1'b1, 1'b1, ST_OPS_ADJ,       16'd2, 8'h00},
    '{CH_CLOSE, 1'b0, 1'b0, ST_OK,            16'd0, 8'h00},
    '{8'h00,    1'b1, 1'b1, ST_EXTRA_CLOSE,   16'd0, 8'h00},
    '{CH_OPEN,  1'b0, 1'b0, ST_OK,            16'd0, 8'h00},
    '{CH_Z,     1'b0, 1'b0, ST_OK,            16'd0, 8'h00},
    '{CH_XOR,   1'b0, 1'b0, ST_OK,            16'd0, 8'h00},
    '{8'h00,    1'b1, 1'b1, ST_BOTH,          16'd3, 8'h00},
    '{CH_OPEN,  1'b0, 1'b0, ST_OK,            16'd0, 8'h00},
    '{CH_A,     1'b0, 1'b0, ST_OK,            16'd0, 8'h00},
    '{CH_AND,   1'b0, 1'b0, ST_OK,            16'd0, 8'h00},
    '{"B",      1'b0, 1'b0, ST_OK,            16'd0, 8'h00},
    '{CH_CLOSE, 1'b0, 1'b0, ST_OK,            16'd0, 8'h00},
    '{8'h00,    1'b1, 1'b0, ST_OK,            16'd0, 8'h00}
  };

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic void latch_error(input logic [3:0] code, input logic [7:0] ch);
    err_status = code;
    err_index  = char_pos[15:0];
    err_char   = ch;
  endfunction

  // Advances the checker state by one character; returns 1 with the verdict on a terminator.
  function automatic bit judge_char(input logic [7:0] c, input logic last, output verdict_t v);
    bit is_op;
    is_op = c inside {CH_AND, CH_XOR, CH_OR};
    v = '0;
    if (last) begin
      if (err_status != ST_OK) begin
        v.status      = err_status;
        v.error_index = err_index;
        v.error_char  = err_char;
      end else if (char_pos == 0) begin
        v.status = ST_EMPTY;
      end else if (op_pending || depth != 0) begin
        if (op_pending && depth != 0) v.status = ST_BOTH;
        else if (op_pending) v.status = ST_TRAILING_OP;
        else v.status = ST_OPEN_BRACE;
        v.error_index = char_pos[15:0];
      end
      v.term_ok  = (v.status == ST_OK);
      depth      = 0;
      fact_seen  = 0;
      op_pending = 0;
      char_pos   = 0;
      err_status = ST_OK;
      err_index  = '0;
      err_char   = '0;
      return 1'b1;
    end
    if (err_status == ST_OK) begin
      if (char_pos == 0 && is_op) begin
        latch_error(ST_ILLEGAL_START, 8'h00);
      end else if (c == CH_OPEN) begin
        if (depth >= MAX_DEPTH) latch_error(ST_TOO_DEEP, 8'h00);
        else depth++;
      end else if (c == CH_CLOSE) begin
        if (depth == 0) latch_error(ST_EXTRA_CLOSE, 8'h00);
        else depth--;
      end else if (c >= CH_A && c <= CH_Z) begin
        if (!fact_seen) begin
          fact_seen  = 1'b1;
          op_pending = 1'b0;
        end else begin
          latch_error(ST_FACTS_ADJ, 8'h00);
        end
      end else if (is_op) begin
        if (fact_seen && !op_pending) begin
          fact_seen  = 1'b0;
          op_pending = 1'b1;
        end else begin
          latch_error(ST_OPS_ADJ, 8'h00);
        end
      end else if (c != CH_NOT) begin
        latch_error(ST_UNKNOWN, c);
      end
    end
    if (char_pos < POS_MAX) char_pos++;
    return 1'b0;
  endfunction

  function automatic logic [7:0] pick_op();
    case ($urandom_range(0, 2))
      0: return CH_AND;
      1: return CH_XOR;
      default: return CH_OR;
    endcase
  endfunction

  function automatic logic [7:0] pick_symbol();
    case ($urandom_range(0, 5))
      0: return pick_op();
      1: return $urandom_range(0, 1) ? CH_OPEN : CH_CLOSE;
      2: return CH_A + 8'($urandom_range(0, 25));
      3: return CH_NOT;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // Well-formed term with random content, sometimes broken afterwards.
  function automatic void build_term();
    int n_facts;
    int open;
    int k;
    int pos;
    term_q.delete();
    open = 0;
    n_facts = $urandom_range(1, 4);
    for (int i = 0; i < n_facts; i++) begin
      repeat ($urandom_range(0, 2)) begin
        if ($urandom_range(0, 1)) begin
          term_q.push_back(CH_NOT);
        end else begin
          term_q.push_back(CH_OPEN);
          open++;
        end
      end
      term_q.push_back(CH_A + 8'($urandom_range(0, 25)));
      k = $urandom_range(0, open);
      repeat (k) term_q.push_back(CH_CLOSE);
      open -= k;
      if (i < n_facts - 1) term_q.push_back(pick_op());
    end
    repeat (open) term_q.push_back(CH_CLOSE);
    if ($urandom_range(0, 99) < 35) begin
      pos = $urandom_range(0, term_q.size() - 1);
      case ($urandom_range(0, 4))
        0: term_q[pos] = 8'($urandom_range(0, 255));
        1: term_q.insert(pos, pick_symbol());
        2: repeat ($urandom_range(1, 2)) if (term_q.size() > 1) void'(term_q.pop_back());
        3: term_q.insert(pos, term_q[pos]);
        default: begin
          term_q.delete();
          repeat ($urandom_range(0, 8)) term_q.push_back(pick_symbol());
        end
      endcase
    end
  endfunction

  task automatic report_mismatch(input string msg);
    mismatches++;
    $display("[%0t] mismatch: %s", $time, msg);
  endtask

  task automatic send_item(input logic [7:0] c, input logic last, input bit typed = 1'b0,
                           input verdict_t typed_v = '0);
    verdict_t predicted;
    while (!steady && $urandom_range(0, 99) < 32) begin
      term_in.valid <= 1'b0;
      @(posedge clk);
    end
    term_in.valid     <= 1'b1;
    term_in.char_code <= c;
    term_in.term_end  <= last;
    do @(posedge clk); while (!term_in.ready);
    items_sent++;
    if (judge_char(c, last, predicted)) pending_verdicts.push_back(typed ? typed_v : predicted);
  endtask

  task automatic send_term();
    foreach (term_q[i]) send_item(term_q[i], 1'b0);
    send_item(8'($urandom_range(0, 255)), 1'b1);
  endtask

  task automatic drain_verdicts();
    term_in.valid <= 1'b0;
    do @(posedge clk); while (pending_verdicts.size() != 0);
  endtask

  // stimulus
  initial begin
    int unsigned base;
    int term_no;
    verdict_t want;
    rst               <= 1'b1;
    term_in.valid     <= 1'b0;
    term_in.char_code <= 8'h00;
    term_in.term_end  <= 1'b0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    foreach (probes[i]) begin
      want.term_ok     = (probes[i].status == ST_OK);
      want.status      = probes[i].status;
      want.error_index = probes[i].index;
      want.error_char  = probes[i].bad;
      send_item(probes[i].c, probes[i].last, probes[i].typed, want);
    end

    base = items_sent;
    term_no = 0;
    while (items_sent - base < RANDOM_ITEMS) begin
      steady = (term_no >= 60 && term_no < 90);
      if (term_no == 110) drain_verdicts();
      build_term();
      send_term();
      term_no++;
    end
    steady = 0;

    // deepest legal nesting, then one level too deep
    term_q.delete();
    repeat (MAX_DEPTH) term_q.push_back(CH_OPEN);
    term_q.push_back(CH_A);
    repeat (MAX_DEPTH) term_q.push_back(CH_CLOSE);
    send_term();
    term_q.delete();
    repeat (MAX_DEPTH + 1) term_q.push_back(CH_OPEN);
    term_q.push_back(CH_A);
    term_q.push_back(CH_CLOSE);
    send_term();

    drain_verdicts();
    repeat (20) @(posedge clk);
    if (mismatches == 0) begin
      $display("PASS logic_term_syntax_checker");
    end else begin
      $display("FAIL logic_term_syntax_checker");
    end
    $finish;
  end

  // verdict sink: random stalls, one long hold-off
  initial begin
    int unsigned rx_cycles;
    rx_cycles = 0;
    verdict.ready <= 1'b0;
    forever begin
      @(posedge clk);
      rx_cycles++;
      if (rx_cycles == 1000) begin
        verdict.ready <= 1'b0;
        repeat (400) @(posedge clk);
      end else begin
        verdict.ready <= steady || ($urandom_range(0, 99) >= 32);
      end
    end
  end

  always @(posedge clk) begin
    verdict_t want;
    if (!rst && verdict.valid && verdict.ready) begin
      if (pending_verdicts.size() == 0) begin
        report_mismatch("verdict transfer with nothing pending");
      end else begin
        want = pending_verdicts.pop_front();
        if (verdict.term_ok !== want.term_ok)
          report_mismatch($sformatf("term_ok %b, want %b", verdict.term_ok, want.term_ok));
        if (verdict.status !== want.status)
          report_mismatch($sformatf("status %0d, want %0d", verdict.status, want.status));
        if (verdict.error_index !== want.error_index)
          report_mismatch($sformatf("error_index %0d, want %0d", verdict.error_index,
                                    want.error_index));
        if (verdict.error_char !== want.error_char)
          report_mismatch($sformatf("error_char %h, want %h", verdict.error_char,
                                    want.error_char));
      end
    end
  end

  always @(posedge clk) begin
    if ((term_in.valid && term_in.ready) || (verdict.valid && verdict.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles == IDLE_LIMIT) begin
        $display("FAIL logic_term_syntax_checker");
        $finish;
      end
    end
  end

endmodule
